>>> rtl/w26tx_pkg.sv
// ----------------------------------------------------------------------------
// w26tx_pkg
// Shared types and constants for the 26-bit Wiegand transmitter.
// ----------------------------------------------------------------------------
package w26tx_pkg;

   localparam int unsigned FRAME_LEN = 26;
   localparam int unsigned IDX_W     = 5;
   localparam int unsigned CNT_W     = 16;
   localparam int unsigned ADDR_W    = 3;
   localparam int unsigned DATA_W    = 32;

   localparam logic [CNT_W-1:0] WIDTH_RESET    = 16'd50;
   localparam logic [CNT_W-1:0] INTERVAL_RESET = 16'd2000;
   localparam logic [CNT_W-1:0] INTERVAL_MIN   = 16'd2;
   localparam logic [CNT_W-1:0] WIDTH_MIN      = 16'd1;

   localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(FRAME_LEN);

   typedef enum logic [0:0] {
      REG_PULSE_WIDTH    = 1'b0,
      REG_PULSE_INTERVAL = 1'b1
   } reg_index_type;

   typedef enum logic [0:0] {
      OP_TICK = 1'b0,
      OP_SEND = 1'b1
   } op_type;

   typedef struct packed {
      logic d0_level;
      logic d1_level;
      logic busy_res;
      logic send_accepted;
      logic frame_done;
   } rsp_type;

endpackage

>>> rtl/wiegand26_transmitter.sv
// ----------------------------------------------------------------------------
// wiegand26_transmitter
// Builds 26-bit Wiegand frames and times the D0/D1 pulses on tick requests.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one request per item: op tick advances time by one
//   tick, op send starts a frame from facility_code and card_number (refused
//   while a frame is in progress). Every request yields exactly one response
//   on the rsp channel with the line levels, busy, accept and done flags as
//   they stand after that request.
//   The APB-style port sets pulse width (address 0) and pulse interval
//   (address 4); write it only while no frame is running.
// Timing:
//   the response to a request is registered in the output buffer; one request
//   per cycle is sustained while responses are drained and the buffer does
//   not fill, with frame state and counters held in a single register stage.
//   A two-entry response buffer (output register plus skid) lets a request
//   be taken while one response waits; req_ready drops only when both hold.
// Reset:
//   synchronous; lines idle high, no frame running, registers back to
//   width 50 and interval 2000, response buffer empty.
// ----------------------------------------------------------------------------
module wiegand26_transmitter
   import w26tx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [7:0]        req_facility_code,
   input  logic [15:0]       req_card_number,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_d0_level,
   output logic              rsp_d1_level,
   output logic              rsp_busy_res,
   output logic              rsp_send_accepted,
   output logic              rsp_frame_done,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [CNT_W-1:0] width_reg_ff, width_reg_in;
   logic [CNT_W-1:0] interval_reg_ff, interval_reg_in;

   logic [FRAME_LEN-1:0] frame_ff, frame_in;
   logic [IDX_W-1:0]     bit_index_ff, bit_index_in;
   logic [CNT_W-1:0]     interval_count_ff, interval_count_in;
   logic [CNT_W-1:0]     width_count_ff, width_count_in;
   logic                 on_one_ff, on_one_in;
   logic                 active_ff, active_in;
   logic                 sending_ff, sending_in;

   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;

   reg_index_type    reg_index;
   logic             cfg_write;
   logic [CNT_W-1:0] eff_interval;
   logic [CNT_W-1:0] eff_width;
   logic [CNT_W-1:0] width_raw;
   logic [FRAME_LEN-1:0] new_frame;
   logic             lead_parity;
   logic             trail_parity;
   logic             accept;
   logic             pop;
   logic             done;
   rsp_type          res;

   // configuration port
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[2]);
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      width_reg_in    = width_reg_ff;
      interval_reg_in = interval_reg_ff;
      prdata          = '0;
      unique case (reg_index)
         REG_PULSE_WIDTH: begin
            prdata = DATA_W'(width_reg_ff);
            if (cfg_write) width_reg_in = pwdata[CNT_W-1:0];
         end
         REG_PULSE_INTERVAL: begin
            prdata = DATA_W'(interval_reg_ff);
            if (cfg_write) interval_reg_in = pwdata[CNT_W-1:0];
         end
         default: prdata = '0;
      endcase
   end

   // effective limits
   assign eff_interval = (interval_reg_ff < INTERVAL_MIN) ? INTERVAL_MIN : interval_reg_ff;
   assign width_raw    = (width_reg_ff == '0) ? WIDTH_MIN : width_reg_ff;
   assign eff_width    = (width_raw >= eff_interval) ? (eff_interval - WIDTH_MIN) : width_raw;

   // frame build, bit 0 goes out first
   assign lead_parity  = ^req_facility_code ^ ^req_card_number[15:12];
   assign trail_parity = ~^req_card_number[11:0];

   always_comb begin
      new_frame     = '0;
      new_frame[0]  = lead_parity;
      new_frame[25] = trail_parity;
      for (int i = 0; i < 8; i++) begin
         new_frame[8-i] = req_facility_code[i];
      end
      for (int i = 0; i < 16; i++) begin
         new_frame[24-i] = req_card_number[i];
      end
   end

   // handshake
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   // frame state update
   always_comb begin
      frame_in          = frame_ff;
      bit_index_in      = bit_index_ff;
      interval_count_in = interval_count_ff;
      width_count_in    = width_count_ff;
      on_one_in         = on_one_ff;
      active_in         = active_ff;
      sending_in        = sending_ff;
      done              = 1'b0;
      res               = '0;
      if (accept) begin
         if (op_type'(req_op) == OP_SEND) begin
            if (!sending_ff) begin
               frame_in          = new_frame;
               bit_index_in      = '0;
               interval_count_in = '0;
               width_count_in    = '0;
               active_in         = 1'b0;
               on_one_in         = 1'b0;
               sending_in        = 1'b1;
               res.send_accepted = 1'b1;
            end
         end else if (sending_ff) begin
            if (active_ff) begin
               width_count_in = width_count_ff + 1'b1;
               if (width_count_in >= eff_width) begin
                  active_in = 1'b0;
                  if (bit_index_ff >= LAST_BIT) begin
                     sending_in = 1'b0;
                     done       = 1'b1;
                  end
               end
            end
            if (sending_in && (bit_index_ff < LAST_BIT)) begin
               interval_count_in = interval_count_ff + 1'b1;
               if (interval_count_in >= eff_interval) begin
                  interval_count_in = '0;
                  width_count_in    = '0;
                  on_one_in         = frame_ff[0];
                  frame_in          = frame_ff >> 1;
                  active_in         = 1'b1;
                  bit_index_in      = bit_index_ff + 1'b1;
               end
            end
         end
      end
      res.d0_level   = !(active_in && !on_one_in);
      res.d1_level   = !(active_in && on_one_in);
      res.busy_res   = sending_in;
      res.frame_done = done;
   end

   // response buffer
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_reg_ff      <= WIDTH_RESET;
         interval_reg_ff   <= INTERVAL_RESET;
         frame_ff          <= '0;
         bit_index_ff      <= '0;
         interval_count_ff <= '0;
         width_count_ff    <= '0;
         on_one_ff         <= 1'b0;
         active_ff         <= 1'b0;
         sending_ff        <= 1'b0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         width_reg_ff      <= width_reg_in;
         interval_reg_ff   <= interval_reg_in;
         frame_ff          <= frame_in;
         bit_index_ff      <= bit_index_in;
         interval_count_ff <= interval_count_in;
         width_count_ff    <= width_count_in;
         on_one_ff         <= on_one_in;
         active_ff         <= active_in;
         sending_ff        <= sending_in;
         out_valid_ff      <= out_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_d0_level      = out_ff.d0_level;
   assign rsp_d1_level      = out_ff.d1_level;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_send_accepted = out_ff.send_accepted;
   assign rsp_frame_done    = out_ff.frame_done;

endmodule

>>> rtl/w26tx_checker.sv
// ----------------------------------------------------------------------------
// w26tx_checker
// Port-level checks on the response channel of the Wiegand transmitter.
// ----------------------------------------------------------------------------
module w26tx_checker
   import w26tx_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_d0_level,
   input logic rsp_d1_level,
   input logic rsp_busy_res,
   input logic rsp_send_accepted,
   input logic rsp_frame_done
);

   rsp_type rsp_view;

   assign rsp_view = '{d0_level: rsp_d0_level, d1_level: rsp_d1_level,
                       busy_res: rsp_busy_res, send_accepted: rsp_send_accepted,
                       frame_done: rsp_frame_done};

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_view))
      else $error("response changed while stalled");

   // never both lines low
   a_one_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_d0_level || rsp_d1_level)
      else $error("both data lines low");

   // accepted send leaves the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_accepted |-> rsp_busy_res && !rsp_frame_done)
      else $error("accepted send without busy");

   // idle lines high
   a_idle_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_d0_level && rsp_d1_level)
      else $error("line low while idle");

   // done ends the frame
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_busy_res && !rsp_send_accepted)
      else $error("frame done while still busy");

endmodule

bind wiegand26_transmitter w26tx_checker u_w26tx_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_d0_level      (rsp_d0_level),
   .rsp_d1_level      (rsp_d1_level),
   .rsp_busy_res      (rsp_busy_res),
   .rsp_send_accepted (rsp_send_accepted),
   .rsp_frame_done    (rsp_frame_done)
);

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 26-bit Wiegand transmitter: a behavioral copy of
// the frame builder and pulse timer predicts the line levels and flags after
// every request, and each response is compared field by field. Directed
// frames cover extreme codes, refused sends and timing clamps; random frames
// then run under four handshake pressure phases.
// ----------------------------------------------------------------------------
module tb_top;
   import w26tx_pkg::*;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 11;
   localparam int DRAIN_CYCLES   = 8;
   localparam int TOTAL_ITEMS    = 650;
   localparam int MAX_PRINTED    = 40;
   localparam int TIMEOUT_CYCLES = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_op = 1'b0;
   logic [7:0]        req_facility_code = '0;
   logic [15:0]       req_card_number = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_d0_level;
   logic              rsp_d1_level;
   logic              rsp_busy_res;
   logic              rsp_send_accepted;
   logic              rsp_frame_done;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   wiegand26_transmitter dut (.*);

   always #CLOCK_HALF clock = ~clock;

   // predicted transmitter state
   logic [CNT_W-1:0]     cfg_width = WIDTH_RESET;
   logic [CNT_W-1:0]     cfg_interval = INTERVAL_RESET;
   logic [FRAME_LEN-1:0] frame_bits = '0;
   logic [IDX_W-1:0]     next_bit = '0;
   logic [CNT_W-1:0]     interval_cnt = '0;
   logic [CNT_W-1:0]     width_cnt = '0;
   logic                 line_is_d1 = 1'b0;
   logic                 pulse_on = 1'b0;
   logic                 frame_busy = 1'b0;

   rsp_type line_state_q[$];
   rsp_type want_line;

   int error_count = 0;
   int checked_count = 0;
   int items_sent = 0;
   int frames_done = 0;
   int sends_refused = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic predict_line_state(op_type op, logic [7:0] fac, logic [15:0] card);
      logic [CNT_W-1:0] eff_iv;
      logic [CNT_W-1:0] eff_w;
      rsp_type r;
      eff_iv = (cfg_interval < INTERVAL_MIN) ? INTERVAL_MIN : cfg_interval;
      eff_w = (cfg_width == '0) ? WIDTH_MIN : cfg_width;
      if (eff_w >= eff_iv)
         eff_w = eff_iv - 1'b1;
      r = '0;
      if (op == OP_SEND) begin
         if (!frame_busy) begin
            for (int i = 0; i < 8; i++)
               frame_bits[8-i] = fac[i];
            for (int i = 0; i < 16; i++)
               frame_bits[24-i] = card[i];
            frame_bits[0] = ^frame_bits[12:1];
            frame_bits[25] = ~^frame_bits[24:13];
            next_bit = '0;
            interval_cnt = '0;
            width_cnt = '0;
            pulse_on = 1'b0;
            line_is_d1 = 1'b0;
            frame_busy = 1'b1;
            r.send_accepted = 1'b1;
         end else begin
            sends_refused++;
         end
      end else if (frame_busy) begin
         if (pulse_on) begin
            width_cnt = width_cnt + 1'b1;
            if (width_cnt >= eff_w) begin
               pulse_on = 1'b0;
               if (next_bit >= LAST_BIT) begin
                  frame_busy = 1'b0;
                  r.frame_done = 1'b1;
                  frames_done++;
               end
            end
         end
         if (frame_busy && next_bit < LAST_BIT) begin
            interval_cnt = interval_cnt + 1'b1;
            if (interval_cnt >= eff_iv) begin
               interval_cnt = '0;
               width_cnt = '0;
               line_is_d1 = frame_bits[next_bit];
               pulse_on = 1'b1;
               next_bit = next_bit + 1'b1;
            end
         end
      end
      r.d0_level = !(pulse_on && !line_is_d1);
      r.d1_level = !(pulse_on && line_is_d1);
      r.busy_res = frame_busy;
      line_state_q.push_back(r);
   endtask

   task automatic send_request(op_type op, logic [7:0] fac, logic [15:0] card);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_facility_code <= fac;
      req_card_number <= card;
      do @(posedge clock); while (!req_ready);
      predict_line_state(op, fac, card);
      items_sent++;
   endtask

   task automatic send_tick();
      send_request(OP_TICK, 8'($urandom), 16'($urandom));
   endtask

   // ticks until the predicted frame ends, with refused sends mixed in
   task automatic finish_frame(int refuse_pct);
      while (frame_busy) begin
         if ($urandom_range(99) < refuse_pct)
            send_request(OP_SEND, 8'($urandom), 16'($urandom));
         else
            send_tick();
      end
   endtask

   task automatic run_frame(logic [7:0] fac, logic [15:0] card, int refuse_pct);
      send_request(OP_SEND, fac, card);
      finish_frame(refuse_pct);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (line_state_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(reg_index_type idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(4 * int'(idx));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_PULSE_WIDTH)
         cfg_width = value[15:0];
      else
         cfg_interval = value[15:0];
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(reg_index_type idx);
      logic [15:0] want;
      want = (idx == REG_PULSE_WIDTH) ? cfg_width : cfg_interval;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_W'(4 * int'(idx));
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[15:0] !== want)
         report_mismatch(idx == REG_PULSE_WIDTH ? "pulse width register"
                                                : "pulse interval register",
                         prdata, 32'(want));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(logic [31:0] width_value, logic [31:0] interval_value);
      wait_for_drain();
      write_register(REG_PULSE_WIDTH, width_value);
      write_register(REG_PULSE_INTERVAL, interval_value);
      check_register(REG_PULSE_WIDTH);
      check_register(REG_PULSE_INTERVAL);
   endtask

   task automatic test_register_reset();
      check_register(REG_PULSE_WIDTH);
      check_register(REG_PULSE_INTERVAL);
      // ticks with no frame running change nothing
      send_tick();
      send_tick();
   endtask

   task automatic test_frame_contents();
      set_timing(32'd1, 32'd2);
      send_request(OP_SEND, 8'h00, 16'h0000);
      send_request(OP_SEND, 8'hFF, 16'hFFFF);
      finish_frame(0);
      run_frame(8'hFF, 16'hFFFF, 0);
      run_frame(8'hA5, 16'h5A3C, 0);
   endtask

   task automatic test_timing_limits();
      // zero width and interval fall back to the minimum
      set_timing(32'd0, 32'd0);
      run_frame(8'h81, 16'h8001, 0);
      set_timing(32'h0000_FFFF, 32'd1);
      run_frame(8'h3C, 16'hC33C, 0);
      // width equal to interval is clamped
      set_timing(32'd3, 32'd3);
      run_frame(8'h5A, 16'hA5C3, 0);
      // upper data bits are dropped
      set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_tick();
      send_tick();
   endtask

   task automatic test_random_traffic();
      int idle_pct [4] = '{0, 51, 0, 16};
      int stall_pct [4] = '{0, 0, 51, 16};
      int target;
      logic [31:0] interval_value;
      logic [31:0] width_value;
      for (int phase = 0; phase < 4; phase++) begin
         wait_for_drain();
         send_idle_pct = idle_pct[phase];
         rsp_stall_pct = stall_pct[phase];
         target = items_sent + (TOTAL_ITEMS - items_sent) / (4 - phase);
         do begin
            case ($urandom_range(9))
               0: interval_value = $urandom_range(1, 0);
               1: interval_value = $urandom_range(5, 4);
               default: interval_value = $urandom_range(3, 2);
            endcase
            if ($urandom_range(9) == 0)
               width_value = 32'h0000_FFFF;
            else
               width_value = $urandom_range(interval_value + 1, 0);
            if ($urandom_range(7) == 0)
               width_value = width_value | ($urandom & 32'hFFFF_0000);
            set_timing(width_value, interval_value);
            repeat ($urandom_range(3, 0)) send_tick();
            run_frame(8'($urandom), 16'($urandom), 6);
         end while (items_sent < target);
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_state_q.size() == 0) begin
            report_mismatch("response with no request outstanding", 0, 0);
         end else begin
            want_line = line_state_q.pop_front();
            if (rsp_d0_level !== want_line.d0_level)
               report_mismatch("d0 level", rsp_d0_level, want_line.d0_level);
            if (rsp_d1_level !== want_line.d1_level)
               report_mismatch("d1 level", rsp_d1_level, want_line.d1_level);
            if (rsp_busy_res !== want_line.busy_res)
               report_mismatch("busy", rsp_busy_res, want_line.busy_res);
            if (rsp_send_accepted !== want_line.send_accepted)
               report_mismatch("send accepted", rsp_send_accepted, want_line.send_accepted);
            if (rsp_frame_done !== want_line.frame_done)
               report_mismatch("frame done", rsp_frame_done, want_line.frame_done);
            checked_count++;
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_reset();
      test_frame_contents();
      test_timing_limits();
      test_random_traffic();
      wait_for_drain();
      $display("run covered %0d requests: %0d frames sent, %0d sends refused while busy",
               items_sent, frames_done, sends_refused);
      $display("%0d responses checked under four handshake pressure phases, %0d mismatches",
               checked_count, error_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 2 * CLOCK_HALF);
      $display("timeout with %0d responses outstanding", line_state_q.size());
      $display("Verification failed");
      $finish;
   end

endmodule
